@@ design/smms_pkg.sv @@
// Shared constants and types for the run statistics block.
package smms_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int DATA_W = 32;
	localparam int COUNT_W = 11;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS,
		S_WRX,
		S_MED0,
		S_MED1,
		S_MED2,
		S_MUL1,
		S_MUL2,
		S_DIVV,
		S_SQRT,
		S_DIVM,
		S_DONE
	} state_t;

endpackage

@@ design/smms_in_if.sv @@
// Sample request channel: valid, ready and one Q16.16 sample with its last mark.
interface smms_in_if;
	logic valid;
	logic ready;
	logic signed [smms_pkg::DATA_W-1:0] sample;
	logic last;

	modport source(output valid, output sample, output last, input ready);
	modport sink(input valid, input sample, input last, output ready);
endinterface

@@ design/smms_out_if.sv @@
// Result request channel: valid, ready and the statistics of one run.
interface smms_out_if;
	logic valid;
	logic ready;
	logic signed [smms_pkg::DATA_W-1:0] median_value;
	logic signed [smms_pkg::DATA_W-1:0] mean_value;
	logic [smms_pkg::DATA_W-1:0] std_dev;
	logic [smms_pkg::COUNT_W-1:0] sample_count;
	logic [smms_pkg::STATUS_W-1:0] status;

	modport source(output valid, output median_value, output mean_value, output std_dev,
		output sample_count, output status, input ready);
	modport sink(input valid, input median_value, input mean_value, input std_dev,
		input sample_count, input status, output ready);
endinterface

@@ design/smms_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module smms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/sample_median_mean_stddev.sv @@
// Run statistics: median, mean and sample standard deviation of a Q16.16 sample run.
// Usage:
//   samples: one signed Q16.16 sample per request; last closes the run.
//   results: one request per run with median, mean, standard deviation (n-1),
//   the kept count and a status (ok, single sample, samples dropped).
// Each kept sample is inserted in sorted order in the sample RAM, moving one entry
// per cycle. Samples beyond MAX_SAMPLES are dropped and flagged.
// After the last sample, a sequencer finishes the run: it reads the median,
// then runs two products on a shift-add multiplier, the variance division on
// a restoring divider, a bit-serial square root and the mean division; the
// multiplier, divider and square root each run one bit per cycle.
// One result waits in the output register; samples of the next run are taken
// while it waits, and the next run's result holds until the receiver is ready.
// Reset clears the count, the flags and the output valid; the RAM is not cleared.
module sample_median_mean_stddev #(
	parameter int MAX_SAMPLES = smms_pkg::MAX_SAMPLES_DEF
) (
	input logic clk,
	input logic arst_n,
	smms_in_if.sink samples,
	smms_out_if.source results
);
	localparam int DW = smms_pkg::DATA_W;
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int S1W = DW + CW;
	localparam int S2W = 2 * DW + CW;
	localparam int QW = 2 * DW + 2 * CW;
	localparam int VW = 2 * CW;
	localparam int KW = $clog2(QW + 1);
	localparam int XW = CW + smms_pkg::COUNT_W;

	smms_pkg::state_t state_q, state_nx;

	logic [CW-1:0] cnt_q, pos_q;
	logic ovf_q, last_q, sqv_s1, ov_q;
	logic signed [DW-1:0] x_q, mhi_q, med_q, mean_q;
	logic [DW-1:0] sd_q;
	logic signed [S1W-1:0] s1_q;
	logic [S2W-1:0] s2_q;
	logic [2*DW-1:0] sq_s1;
	logic [QW-1:0] acc_q, mc_q, p1_q, dq_q;
	logic [S1W-1:0] mp_q;
	logic [VW-1:0] rem_q, dv_q;
	logic [KW-1:0] it_q;
	logic [2*DW-1:0] sv_q, sr_q, sb_q;

	logic in_acc, kept;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic signed [DW-1:0] rd_s;
	logic [DW-1:0] abs_x;
	logic [S1W-1:0] abs_s1;
	logic [QW-1:0] acc_nx, q_nx;
	logic [VW:0] dr, dsub;
	logic dge;
	logic [2*DW-1:0] st_sum, sr_nx, sv_nx;
	logic signed [DW:0] msum, mrnd;
	logic [CW-1:0] half, half_m1, pos_m2, cnt_m1;
	logic mul_end, div_end, sqrt_end, out_free, gt;
	logic [XW-1:0] cnt_ext;

	smms_ram #(.WIDTH(DW), .DEPTH(MAX_SAMPLES)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign rd_s = ram_rdata;
	assign in_acc = samples.valid && samples.ready;
	assign kept = cnt_q < CW'(MAX_SAMPLES);
	assign abs_x = samples.sample[DW-1] ? DW'(-samples.sample) : DW'(samples.sample);
	assign abs_s1 = s1_q[S1W-1] ? S1W'(-s1_q) : S1W'(s1_q);
	assign gt = rd_s > x_q;
	assign half = cnt_q >> 1;
	assign half_m1 = half - CW'(1);
	assign pos_m2 = pos_q - CW'(2);
	assign cnt_m1 = cnt_q - CW'(1);
	assign acc_nx = acc_q + (mp_q[0] ? mc_q : '0);
	assign mul_end = it_q == KW'(S1W - 1);
	assign div_end = it_q == KW'(QW - 1);
	assign sqrt_end = it_q == KW'(DW - 1);
	assign dr = {rem_q, dq_q[QW-1]};
	assign dge = dr >= {1'b0, dv_q};
	assign dsub = dr - {1'b0, dv_q};
	assign q_nx = {dq_q[QW-2:0], dge};
	assign st_sum = sr_q + sb_q;
	assign sv_nx = (sv_q >= st_sum) ? sv_q - st_sum : sv_q;
	assign sr_nx = (sv_q >= st_sum) ? (sr_q >> 1) + sb_q : sr_q >> 1;
	assign msum = (DW+1)'(mhi_q) + (DW+1)'(rd_s);
	assign mrnd = msum + ((msum[DW] && msum[0]) ? (DW+1)'(1) : (DW+1)'(0));
	assign out_free = !ov_q || results.ready;
	assign cnt_ext = XW'(cnt_q);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			smms_pkg::S_IDLE: begin
				if (in_acc) begin
					if (kept && cnt_q != '0) state_nx = smms_pkg::S_INS;
					else if (samples.last) state_nx = smms_pkg::S_MED0;
				end
			end
			smms_pkg::S_INS: begin
				if (gt && pos_q == CW'(1)) state_nx = smms_pkg::S_WRX;
				else if (!gt) state_nx = last_q ? smms_pkg::S_MED0 : smms_pkg::S_IDLE;
			end
			smms_pkg::S_WRX: state_nx = last_q ? smms_pkg::S_MED0 : smms_pkg::S_IDLE;
			smms_pkg::S_MED0: state_nx = smms_pkg::S_MED1;
			smms_pkg::S_MED1: state_nx = smms_pkg::S_MED2;
			smms_pkg::S_MED2: state_nx = smms_pkg::S_MUL1;
			smms_pkg::S_MUL1: if (mul_end) state_nx = smms_pkg::S_MUL2;
			smms_pkg::S_MUL2: if (mul_end) state_nx = smms_pkg::S_DIVV;
			smms_pkg::S_DIVV: if (div_end) state_nx = smms_pkg::S_SQRT;
			smms_pkg::S_SQRT: if (sqrt_end) state_nx = smms_pkg::S_DIVM;
			smms_pkg::S_DIVM: if (div_end) state_nx = smms_pkg::S_DONE;
			smms_pkg::S_DONE: if (out_free) state_nx = smms_pkg::S_IDLE;
			default: state_nx = smms_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = AW'(pos_q);
		ram_wdata = x_q;
		ram_raddr = AW'(pos_m2);
		unique case (state_q)
			smms_pkg::S_IDLE: begin
				samples.ready = 1'b1;
				ram_raddr = AW'(cnt_m1);
				ram_wdata = samples.sample;
				ram_waddr = '0;
				ram_we = in_acc && kept && cnt_q == '0;
			end
			smms_pkg::S_INS: begin
				ram_we = 1'b1;
				ram_wdata = gt ? ram_rdata : x_q;
			end
			smms_pkg::S_WRX: begin
				ram_we = 1'b1;
				ram_waddr = '0;
			end
			smms_pkg::S_MED0: ram_raddr = AW'(half);
			smms_pkg::S_MED1: ram_raddr = AW'(half_m1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smms_pkg::S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sqv_s1 <= 1'b0;
			ov_q <= 1'b0;
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			state_q <= state_nx;
			sqv_s1 <= 1'b0;
			if (sqv_s1) s2_q <= s2_q + S2W'(sq_s1);
			if (state_q == smms_pkg::S_DONE && out_free) ov_q <= 1'b1;
			else if (ov_q && results.ready) ov_q <= 1'b0;
			case (state_q)
				smms_pkg::S_IDLE: begin
					if (in_acc) begin
						if (kept) begin
							s1_q <= s1_q + S1W'(samples.sample);
							sqv_s1 <= 1'b1;
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				smms_pkg::S_DONE: begin
					if (out_free) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						s1_q <= '0;
						s2_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			smms_pkg::S_IDLE: begin
				sq_s1 <= abs_x * abs_x;
				x_q <= samples.sample;
				pos_q <= cnt_q;
				last_q <= samples.last;
			end
			smms_pkg::S_INS: if (gt) pos_q <= pos_q - CW'(1);
			smms_pkg::S_MED1: mhi_q <= rd_s;
			smms_pkg::S_MED2: begin
				med_q <= cnt_q[0] ? mhi_q : DW'(mrnd >>> 1);
				acc_q <= '0;
				mc_q <= QW'(abs_s1);
				mp_q <= abs_s1;
				it_q <= '0;
			end
			smms_pkg::S_MUL1: begin
				if (mul_end) begin
					p1_q <= acc_nx;
					acc_q <= '0;
					mc_q <= QW'(s2_q);
					mp_q <= S1W'(cnt_q);
					it_q <= '0;
				end else begin
					acc_q <= acc_nx;
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
					it_q <= it_q + KW'(1);
				end
			end
			smms_pkg::S_MUL2: begin
				if (mul_end) begin
					dq_q <= acc_nx - p1_q;
					rem_q <= '0;
					dv_q <= VW'(cnt_q) * VW'(cnt_m1);
					it_q <= '0;
				end else begin
					acc_q <= acc_nx;
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
					it_q <= it_q + KW'(1);
				end
			end
			smms_pkg::S_DIVV, smms_pkg::S_DIVM: begin
				rem_q <= dge ? dsub[VW-1:0] : dr[VW-1:0];
				dq_q <= q_nx;
				if (div_end) begin
					it_q <= '0;
					if (state_q == smms_pkg::S_DIVV) begin
						sv_q <= (|q_nx[QW-1:2*DW]) ? '1 : q_nx[2*DW-1:0];
						sr_q <= '0;
						sb_q <= (2*DW)'(1) << (2*DW - 2);
					end else begin
						mean_q <= s1_q[S1W-1] ? DW'(-q_nx[DW-1:0]) : DW'(q_nx[DW-1:0]);
					end
				end else begin
					it_q <= it_q + KW'(1);
				end
			end
			smms_pkg::S_SQRT: begin
				sv_q <= sv_nx;
				sr_q <= sr_nx;
				sb_q <= sb_q >> 2;
				if (sqrt_end) begin
					sd_q <= (cnt_q < CW'(2)) ? '0 : sr_nx[DW-1:0];
					dq_q <= QW'(abs_s1);
					rem_q <= '0;
					dv_q <= VW'(cnt_q);
					it_q <= '0;
				end else begin
					it_q <= it_q + KW'(1);
				end
			end
			smms_pkg::S_DONE: begin
				if (out_free) begin
					results.median_value <= med_q;
					results.mean_value <= mean_q;
					results.std_dev <= sd_q;
					results.sample_count <= cnt_ext[smms_pkg::COUNT_W-1:0];
					results.status <= ovf_q ? smms_pkg::ST_DROP :
						(cnt_q == CW'(1) ? smms_pkg::ST_SINGLE : smms_pkg::ST_OK);
				end
			end
			default: ;
		endcase
	end

	assign results.valid = ov_q;
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the run statistics block: median, mean and standard deviation.
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic signed [smms_pkg::DATA_W-1:0] median_value;
		logic signed [smms_pkg::DATA_W-1:0] mean_value;
		logic [smms_pkg::DATA_W-1:0] std_dev;
		logic [smms_pkg::COUNT_W-1:0] sample_count;
		logic [smms_pkg::STATUS_W-1:0] status;
	} run_stats_t;

	logic clk;
	logic arst_n;

	smms_in_if in_ch();
	smms_out_if out_ch();

	sample_median_mean_stddev u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.results(out_ch)
	);

	run_stats_t stats_due[$];
	int sorted_run[$];
	bit run_dropped;
	int err_count;
	bit idle_on;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("sample_median_mean_stddev verification failed");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = '0;
		bitv = 64'h1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic run_stats_t run_summary();
		run_stats_t r;
		longint n;
		longint s1;
		longint med;
		logic [127:0] s2;
		logic [127:0] abs1;
		logic [127:0] q;
		logic [127:0] v;
		logic [63:0] ax;
		n = sorted_run.size();
		s1 = 0;
		s2 = '0;
		foreach (sorted_run[i]) begin
			s1 += sorted_run[i];
			ax = sorted_run[i] < 0 ? -longint'(sorted_run[i]) : longint'(sorted_run[i]);
			s2 += 128'(ax) * 128'(ax);
		end
		if (n % 2 == 1)
			med = sorted_run[n / 2];
		else
			med = (longint'(sorted_run[n / 2]) + longint'(sorted_run[n / 2 - 1])) / 2;
		r.median_value = med[31:0];
		r.mean_value = 32'(s1 / n);
		r.std_dev = '0;
		if (n >= 2) begin
			abs1 = s1 < 0 ? 128'(-s1) : 128'(s1);
			q = 128'(n) * s2 - abs1 * abs1;
			v = q / (128'(n) * 128'(n - 1));
			if (v[127:64] != 0) v = 128'({64{1'b1}});
			r.std_dev = floor_sqrt(v[63:0]) > 64'hFFFF_FFFF ? 32'hFFFF_FFFF
				: 32'(floor_sqrt(v[63:0]));
		end
		r.sample_count = n[smms_pkg::COUNT_W-1:0];
		r.status = run_dropped ? smms_pkg::ST_DROP :
			(n == 1 ? smms_pkg::ST_SINGLE : smms_pkg::ST_OK);
		return r;
	endfunction

	function automatic void take_sample(int s, bit is_last);
		int idx;
		if (sorted_run.size() < smms_pkg::MAX_SAMPLES_DEF) begin
			idx = sorted_run.size();
			while (idx > 0 && sorted_run[idx - 1] > s) idx--;
			sorted_run.insert(idx, s);
		end else begin
			run_dropped = 1'b1;
		end
		if (is_last) begin
			stats_due.push_back(run_summary());
			sorted_run.delete();
			run_dropped = 1'b0;
		end
	endfunction

	task automatic send_sample(logic [31:0] s, bit is_last);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 17) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.last <= is_last;
		do @(posedge clk); while (!in_ch.ready);
		take_sample(int'(s), is_last);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		in_ch.last <= 1'b0;
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($signed($urandom_range(200)) - 100);
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic send_run(int len);
		for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
	endtask

	task automatic test_extremes();
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'h0000_0000, 1'b1);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_odd_even();
		send_sample(32'h0003_0000, 1'b0);
		send_sample(32'hFFFF_0000, 1'b0);
		send_sample(32'h0001_8000, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0002, 1'b0);
		send_sample(32'hFFFF_FFFC, 1'b0);
		send_sample(32'h0000_0001, 1'b1);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'h0000_0002, 1'b0);
		send_sample(32'h0000_0005, 1'b0);
		send_sample(32'hFFFF_FFF0, 1'b1);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < smms_pkg::MAX_SAMPLES_DEF + 3; i++)
			send_sample(pick_sample(), i == smms_pkg::MAX_SAMPLES_DEF + 2);
		for (int i = 0; i < 64; i++)
			send_sample($urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF,
				i == 63);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int r = 0; r < 30; r++) send_run($urandom_range(3, 1));
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 600) begin
			int len;
			idle_on = !(sent >= 200 && sent < 320);
			case ($urandom_range(19))
				0: len = 1;
				1: len = $urandom_range(300, 100);
				default: len = $urandom_range(24, 2);
			endcase
			if ($urandom_range(15) == 0) begin
				for (int i = 0; i < len; i++) send_sample($urandom, 1'b0);
				send_sample(pick_sample(), 1'b1);
				sent += 1;
			end else begin
				send_run(len);
			end
			sent += len;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int holding;
		holding = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				holding++;
				if (holding >= 3000) begin
					hold_req = 1'b0;
					holding = 0;
				end
			end else begin
				out_ch.ready <= !(idle_on && $urandom_range(99) < 17);
			end
		end
	end

	always @(posedge clk) begin
		run_stats_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (stats_due.size() == 0) begin
				err_count++;
				if (err_count <= 10) $display("unexpected result request");
			end else begin
				want = stats_due.pop_front();
				if (out_ch.median_value !== want.median_value
						|| out_ch.mean_value !== want.mean_value
						|| out_ch.std_dev !== want.std_dev
						|| out_ch.sample_count !== want.sample_count
						|| out_ch.status !== want.status) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: exp med %h mean %h sd %h n %0d st %0d,",
							want.median_value, want.mean_value, want.std_dev,
							want.sample_count, want.status,
							" got med %h mean %h sd %h n %0d st %0d",
							out_ch.median_value, out_ch.mean_value, out_ch.std_dev,
							out_ch.sample_count, out_ch.status);
				end
			end
		end
	end

	initial begin
		err_count = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		run_dropped = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_odd_even();
		test_overflow();
		test_backpressure();
		test_random();
		stop_sending();
		while (stats_due.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (err_count == 0 && stats_due.size() == 0)
			$display("sample_median_mean_stddev verification clean");
		else
			$display("sample_median_mean_stddev verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/smms_pkg.sv
design/smms_in_if.sv
design/smms_out_if.sv
design/smms_ram.sv
design/sample_median_mean_stddev.sv
bench/testbench.sv
